// File: rtl/pn2d_pkg.sv
// shared types, constants and the gradient function of the 2d gradient noise block
// no dependencies
package pn2d_pkg;

   localparam int TBL_AW  = 8;
   localparam int TBL_DEPTH = 256;
   localparam int GW      = 21;
   localparam logic [16:0] ONE_Q = 17'd65536;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] GRAD_PP = 2'd0;
   localparam logic [1:0] GRAD_NP = 2'd1;
   localparam logic [1:0] GRAD_YX = 2'd2;
   localparam logic [1:0] GRAD_NN = 2'd3;

   typedef struct packed {
      logic              en;
      logic [TBL_AW-1:0] addr;
      logic [7:0]        data;
   } pn2d_wr_type;

   // diagonal gradient picked by the low two hash bits
   function automatic logic signed [GW-1:0] grad(input logic [7:0] hash,
                                                 input logic signed [GW-1:0] x,
                                                 input logic signed [GW-1:0] y);
      logic signed [GW-1:0] g;
      begin
         case (hash[1:0])
            GRAD_PP: g = x + y;
            GRAD_NP: g = y - x;
            GRAD_YX: g = y - x;
            GRAD_NN: g = -y - x;
            default: g = x + y;
         endcase
         grad = g;
      end
   endfunction

endpackage

// File: rtl/perlin_noise_2d_top.sv
// 2d gradient noise block: eight stage pipeline with five copies of the permutation table
// depends on pn2d_pkg, pn2d_perm_mem and pn2d_fade
//
// Each item is either a table load (req_tuser = 0), which rewrites one byte of the
// 256-entry permutation table and gives no result, or a noise query (req_tuser = 1),
// which gives one rsp item holding the noise in q1.16 (0 = 0.0, 65536 = 1.0). One item
// is taken every cycle while the result side does not stall; a query's result is held
// on rsp_tvalid and rsp_tdata until the result side takes it. The three rounds of table
// lookups are served by five copies of the table, one in the first round and two in
// each of the others, each with two read ports; a load walks down the pipeline and
// writes each copy at the stage that reads it, so loads and queries keep their order
// exactly. The quintic fade runs alongside the lookups in its own three stages; the
// corner gradients, the two horizontal blends, the vertical blend and the final halving
// take the remaining stages. After reset the table is in identity order without any
// clearing pass. The whole pipeline holds while a result waits.
module perlin_noise_2d_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // command: 0 load, 1 query
   input  logic [79:0] req_tdata,   // table_index, table_value, x_coord, y_coord
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // noise_value (17 bits), zero padded
);
   import pn2d_pkg::*;

   localparam int CELL_LO = FRAC_BITS;

   // pipeline advances whenever the output slot is free or being emptied
   logic adv;
   logic rsp_valid_ff;
   logic [16:0] noise_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // entry: unpack the item
   logic [31:0]             x_coord, y_coord;
   logic [TBL_AW-1:0]       xi, yi;
   logic [FRAC_BITS+15:0]   xext, yext;
   logic [15:0]             xf, yf;
   logic                    in_load, in_query;

   assign x_coord  = req_tdata[47:16];
   assign y_coord  = req_tdata[79:48];
   assign xi       = x_coord[CELL_LO+TBL_AW-1:CELL_LO];
   assign yi       = y_coord[CELL_LO+TBL_AW-1:CELL_LO];
   // bring the fraction to 16 bits, padding low or truncating as needed
   assign xext     = {x_coord[FRAC_BITS-1:0], 16'd0};
   assign yext     = {y_coord[FRAC_BITS-1:0], 16'd0};
   assign xf       = xext[FRAC_BITS+15:FRAC_BITS];
   assign yf       = yext[FRAC_BITS+15:FRAC_BITS];
   assign in_load  = req_tvalid && (req_tuser == CMD_LOAD);
   assign in_query = req_tvalid && (req_tuser == CMD_QUERY);

   // stage control bits
   logic ld1_ff, ld2_ff;
   logic q1_ff, q2_ff, q3_ff, q4_ff, q5_ff, q6_ff, q7_ff;

   // payload carried along
   logic [7:0]  idx1_ff, val1_ff, idx2_ff, val2_ff;
   logic [7:0]  yi1_ff;
   logic [15:0] xf1_ff, yf1_ff, xf2_ff, yf2_ff, xf3_ff, yf3_ff;

   // first lookup round, copy a read at entry
   pn2d_wr_type wr_a, wr_b, wr_c;
   logic [7:0]  px0, px1;

   assign wr_a = '{en: in_load, addr: req_tdata[7:0], data: req_tdata[15:8]};

   pn2d_perm_mem u_mem_a (
      .clock(clock), .reset(reset), .en(adv), .wr(wr_a),
      .rd_addr_a(xi), .rd_addr_b(xi + 8'd1),
      .rd_data_a(px0), .rd_data_b(px1)
   );

   // second lookup round, corner hashes (wrap modulo 256)
   logic [7:0] aa, ab, ba, bb;

   assign wr_b = '{en: ld1_ff, addr: idx1_ff, data: val1_ff};

   pn2d_perm_mem u_mem_b0 (
      .clock(clock), .reset(reset), .en(adv), .wr(wr_b),
      .rd_addr_a(px0 + yi1_ff), .rd_addr_b(px0 + yi1_ff + 8'd1),
      .rd_data_a(aa), .rd_data_b(ab)
   );

   pn2d_perm_mem u_mem_b1 (
      .clock(clock), .reset(reset), .en(adv), .wr(wr_b),
      .rd_addr_a(px1 + yi1_ff), .rd_addr_b(px1 + yi1_ff + 8'd1),
      .rd_data_a(ba), .rd_data_b(bb)
   );

   // third lookup round, extra table pass on each corner
   logic [7:0] haa, hab, hba, hbb;

   assign wr_c = '{en: ld2_ff, addr: idx2_ff, data: val2_ff};

   pn2d_perm_mem u_mem_c0 (
      .clock(clock), .reset(reset), .en(adv), .wr(wr_c),
      .rd_addr_a(aa), .rd_addr_b(ba),
      .rd_data_a(haa), .rd_data_b(hba)
   );

   pn2d_perm_mem u_mem_c1 (
      .clock(clock), .reset(reset), .en(adv), .wr(wr_c),
      .rd_addr_a(ab), .rd_addr_b(bb),
      .rd_data_a(hab), .rd_data_b(hbb)
   );

   // fade curves, ready in step with the third lookup round
   logic [16:0] fu, fv;

   pn2d_fade u_fade_x (.clock(clock), .en(adv), .t(xf), .fade(fu));
   pn2d_fade u_fade_y (.clock(clock), .en(adv), .t(yf), .fade(fv));

   // gradients at the four corners
   logic signed [GW-1:0] x0s, y0s, x1s, y1s;
   logic signed [GW-1:0] gaa4_ff, gba4_ff, gab4_ff, gbb4_ff;
   logic [16:0]          u4_ff, v4_ff;

   assign x0s = $signed({5'd0, xf3_ff});
   assign y0s = $signed({5'd0, yf3_ff});
   assign x1s = x0s - $signed({4'd0, ONE_Q});
   assign y1s = y0s - $signed({4'd0, ONE_Q});

   // horizontal blend products
   logic signed [GW-1:0]   dx0, dx1;
   logic signed [GW+17:0]  p0_in, p1_in, p0_ff, p1_ff;
   logic signed [GW-1:0]   gaa5_ff, gab5_ff;
   logic [16:0]            v5_ff;

   assign dx0   = gba4_ff - gaa4_ff;
   assign dx1   = gbb4_ff - gab4_ff;
   assign p0_in = $signed({1'b0, u4_ff}) * dx0;
   assign p1_in = $signed({1'b0, u4_ff}) * dx1;

   // floor of product over one, then add the left corner
   logic signed [GW-1:0] x1_ff, x2_ff, x1_in, x2_in;
   logic [16:0]          v6_ff;

   assign x1_in = gaa5_ff + p0_ff[GW+15:16];
   assign x2_in = gab5_ff + p1_ff[GW+15:16];

   // vertical blend product
   logic signed [GW-1:0]  dy;
   logic signed [GW+17:0] p2_in, p2_ff;
   logic signed [GW-1:0]  x1b7_ff;

   assign dy    = x2_ff - x1_ff;
   assign p2_in = $signed({1'b0, v6_ff}) * dy;

   // final: (v + 1) / 2 with floor, saturated to [0, 1]
   logic signed [GW-1:0] r_sum, r_half;
   logic [16:0]          noise_in;

   assign r_sum  = x1b7_ff + p2_ff[GW+15:16] + $signed({4'd0, ONE_Q});
   assign r_half = r_sum >>> 1;
   always_comb begin
      if (r_half < 0) begin
         noise_in = '0;
      end else if (r_half > $signed({4'd0, ONE_Q})) begin
         noise_in = ONE_Q;
      end else begin
         noise_in = r_half[16:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ld1_ff       <= 1'b0;
         ld2_ff       <= 1'b0;
         q1_ff        <= 1'b0;
         q2_ff        <= 1'b0;
         q3_ff        <= 1'b0;
         q4_ff        <= 1'b0;
         q5_ff        <= 1'b0;
         q6_ff        <= 1'b0;
         q7_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         ld1_ff       <= in_load;
         ld2_ff       <= ld1_ff;
         q1_ff        <= in_query;
         q2_ff        <= q1_ff;
         q3_ff        <= q2_ff;
         q4_ff        <= q3_ff;
         q5_ff        <= q4_ff;
         q6_ff        <= q5_ff;
         q7_ff        <= q6_ff;
         rsp_valid_ff <= q7_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         idx1_ff  <= req_tdata[7:0];
         val1_ff  <= req_tdata[15:8];
         yi1_ff   <= yi;
         xf1_ff   <= xf;
         yf1_ff   <= yf;
         idx2_ff  <= idx1_ff;
         val2_ff  <= val1_ff;
         xf2_ff   <= xf1_ff;
         yf2_ff   <= yf1_ff;
         xf3_ff   <= xf2_ff;
         yf3_ff   <= yf2_ff;
         gaa4_ff  <= grad(haa, x0s, y0s);
         gba4_ff  <= grad(hba, x1s, y0s);
         gab4_ff  <= grad(hab, x0s, y1s);
         gbb4_ff  <= grad(hbb, x1s, y1s);
         u4_ff    <= fu;
         v4_ff    <= fv;
         p0_ff    <= p0_in;
         p1_ff    <= p1_in;
         gaa5_ff  <= gaa4_ff;
         gab5_ff  <= gab4_ff;
         v5_ff    <= v4_ff;
         x1_ff    <= x1_in;
         x2_ff    <= x2_in;
         v6_ff    <= v5_ff;
         p2_ff    <= p2_in;
         x1b7_ff  <= x1_ff;
         noise_ff <= noise_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, noise_ff};

endmodule

// File: rtl/pn2d_perm_mem.sv
// one copy of the permutation table: one write port, two registered read ports
// entries never written read as their own index; uses pn2d_pkg
module pn2d_perm_mem (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  pn2d_pkg::pn2d_wr_type     wr,
   input  logic [pn2d_pkg::TBL_AW-1:0] rd_addr_a,
   input  logic [pn2d_pkg::TBL_AW-1:0] rd_addr_b,
   output logic [7:0]                rd_data_a,
   output logic [7:0]                rd_data_b
);
   import pn2d_pkg::*;

   logic [7:0]           mem [TBL_DEPTH];
   logic [TBL_DEPTH-1:0] written_ff;
   logic [7:0]           data_a_ff, data_b_ff;
   logic [TBL_AW-1:0]    addr_a_ff, addr_b_ff;
   logic                 hit_a_ff, hit_b_ff;

   always_ff @(posedge clock) begin
      if (en && wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (en) begin
         data_a_ff <= mem[rd_addr_a];
         data_b_ff <= mem[rd_addr_b];
         addr_a_ff <= rd_addr_a;
         addr_b_ff <= rd_addr_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         hit_a_ff   <= 1'b0;
         hit_b_ff   <= 1'b0;
      end else if (en) begin
         hit_a_ff <= written_ff[rd_addr_a];
         hit_b_ff <= written_ff[rd_addr_b];
         if (wr.en) begin
            written_ff[wr.addr] <= 1'b1;
         end
      end
   end

   // identity order until an entry is loaded
   assign rd_data_a = hit_a_ff ? data_a_ff : 8'(addr_a_ff);
   assign rd_data_b = hit_b_ff ? data_b_ff : 8'(addr_b_ff);

endmodule

// File: rtl/pn2d_fade.sv
// three stage quintic fade 6t^5 - 15t^4 + 10t^3 in q0.16, result capped at one
// uses pn2d_pkg
module pn2d_fade (
   input  logic        clock,
   input  logic        en,
   input  logic [15:0] t,
   output logic [16:0] fade
);
   import pn2d_pkg::*;

   logic [15:0]        t1_ff, t2_ff, t3_ff;
   logic [31:0]        sq;
   logic [31:0]        cube;
   logic signed [21:0] poly;
   logic [20:0]        poly_in, poly_ff;
   logic [36:0]        prod;
   logic [20:0]        prod_hi;
   logic [16:0]        fade_in, fade_ff;

   assign sq   = 32'(t) * 32'(t);
   assign cube = 32'(t2_ff) * 32'(t1_ff);
   assign poly = 22'sd6 * $signed({6'd0, t2_ff}) - 22'sd15 * $signed({6'd0, t1_ff})
               + 22'sd655360;
   assign poly_in = poly[21] ? '0 : poly[20:0];
   assign prod    = 37'(t3_ff) * 37'(poly_ff);
   assign prod_hi = prod[36:16];
   assign fade_in = (prod_hi > 21'(ONE_Q)) ? ONE_Q : prod_hi[16:0];

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff   <= t;
         t2_ff   <= sq[31:16];
         t3_ff   <= cube[31:16];
         poly_ff <= poly_in;
         fade_ff <= fade_in;
      end
   end

   assign fade = fade_ff;

endmodule

// File: rtl/pn2d_checker.sv
// port level checks for the 2d gradient noise block, bound to its top level
// uses pn2d_pkg
module pn2d_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic [79:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   import pn2d_pkg::*;

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // noise stays within [0, 1] with zero padding
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[16:0] <= ONE_Q) && (rsp_tdata[23:17] == 7'd0))
      else $error("noise out of range");

   // nothing comes out right after reset
   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result after reset");

   // input is taken whenever the output slot is free or draining
   a_accept: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("input stalled without cause");

endmodule

bind perlin_noise_2d_top pn2d_checker u_pn2d_checker (.*);
